// ===== sv/link_quality_monitor_unit_macros.svh =====
`ifndef LINK_QUALITY_MONITOR_UNIT_MACROS_SVH
`define LINK_QUALITY_MONITOR_UNIT_MACROS_SVH

// same-cycle implication
`define LQM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link quality monitor check failed");

// next-cycle implication
`define LQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link quality monitor check failed");

`endif

// ===== sv/lqm_pkg.sv =====
`default_nettype none

package lqm_pkg;

   localparam int MS_W  = 12;
   localparam int RUN_W = 4;
   localparam int SUM_W = 16;
   localparam int CNT_W = 4;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [RUN_W-1:0] RUN_MAX = 4'hF;

   localparam logic [1:0] GRADE_GOOD    = 2'd0;
   localparam logic [1:0] GRADE_AVERAGE = 2'd1;
   localparam logic [1:0] GRADE_BAD     = 2'd2;
   localparam logic [1:0] GRADE_NONE    = 2'd3;

   localparam logic [2:0] CSR_GOOD_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_AVERAGE_LIMIT = 3'd1;
   localparam logic [2:0] CSR_STREAK_NEEDED = 3'd2;
   localparam logic [2:0] CSR_BAD_NEEDED    = 3'd3;
   localparam logic [2:0] CSR_FAIL_LIMIT    = 3'd4;

   typedef struct packed {
      logic            probe_ok;
      logic [MS_W-1:0] round_trip_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]      link_grade;
      logic            link_up;
      logic [MS_W-1:0] mean_ms;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/link_quality_monitor_unit.sv =====
// Link quality monitor.
// req channel: one beat per probe (probe_ok, round_trip_ms), valid/stall.
// rsp channel: one beat per probe (link_grade, link_up, mean_ms), valid/stall.
// csr port: csr_write with csr_index 0..4 writes one limit; other indexes do
// nothing. Write only while no probe is in flight.
// A successful probe updates the sample window and running sum in the accept
// cycle, then a bit-serial divider forms sum / count, one quotient bit per
// cycle; the divider's done pulse moves the FSM to ST_FINISH, where the grade
// is formed and the result is written into the output register. A failed
// probe skips the divider and goes from ST_FINISH straight into the output
// register. One probe is worked on at a time: req_stall stays high from the
// accept until its result has entered the output register.
// The output register lets the next probe be accepted while a result waits;
// if the receiver is still stalling when the next result is ready, the block
// holds that result and keeps req_stall high until the register frees.
// Reset restores the limits to 60/150/3/3/3, empties the window, clears all
// run counters, reports good and link down, and drops rsp_valid.
`default_nettype none
`include "link_quality_monitor_unit_macros.svh"

module link_quality_monitor_unit #(
   parameter int WINDOW = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire lqm_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output lqm_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_write,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [lqm_pkg::MS_W-1:0]     csr_data
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_FINISH} state_type;

   state_type                     state_ff, state_in;

   logic [lqm_pkg::MS_W-1:0]      good_limit_ff, good_limit_in;
   logic [lqm_pkg::MS_W-1:0]      avg_limit_ff, avg_limit_in;
   logic [lqm_pkg::RUN_W-1:0]     streak_needed_ff, streak_needed_in;
   logic [lqm_pkg::RUN_W-1:0]     bad_needed_ff, bad_needed_in;
   logic [lqm_pkg::RUN_W-1:0]     fail_limit_ff, fail_limit_in;

   logic [lqm_pkg::MS_W-1:0]      window_ff [WINDOW];
   logic [lqm_pkg::MS_W-1:0]      oldest_sample_ff;
   logic [lqm_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [lqm_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]             oldest_ff, oldest_in;
   logic [lqm_pkg::RUN_W-1:0]     bad_run_ff, bad_run_in;
   logic [1:0]                    last_grade_ff, last_grade_in;
   logic [lqm_pkg::RUN_W-1:0]     grade_run_ff, grade_run_in;
   logic [lqm_pkg::RUN_W-1:0]     fail_run_ff, fail_run_in;
   logic [1:0]                    reported_ff, reported_in;
   logic                          connected_ff, connected_in;
   logic [lqm_pkg::MS_W-1:0]      mean_ff, mean_in;
   logic                          ok_ff, ok_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   lqm_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          accept;
   logic                          full;
   logic [SLOT_W-1:0]             wr_slot;
   logic [lqm_pkg::MS_W-1:0]      old_sample;
   logic                          push;
   logic                          div_done;
   logic [lqm_pkg::SUM_W-1:0]     quotient;
   logic [lqm_pkg::MS_W-1:0]      mean_new;
   logic [1:0]                    grade;
   logic                          out_free;

   assign accept   = req_valid && !req_stall;
   assign push     = accept && req_data.probe_ok;
   assign full     = count_ff == lqm_pkg::CNT_W'(WINDOW);
   assign wr_slot  = full ? oldest_ff : count_ff[SLOT_W-1:0];
   assign old_sample = full ? oldest_sample_ff : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mean_new = quotient[lqm_pkg::MS_W-1:0];

   lqm_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (push),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      if (mean_new <= good_limit_ff) begin
         grade = lqm_pkg::GRADE_GOOD;
      end else if (mean_new <= avg_limit_ff) begin
         grade = lqm_pkg::GRADE_AVERAGE;
      end else begin
         grade = lqm_pkg::GRADE_BAD;
      end
   end

   always_comb begin
      state_in         = state_ff;
      good_limit_in    = good_limit_ff;
      avg_limit_in     = avg_limit_ff;
      streak_needed_in = streak_needed_ff;
      bad_needed_in    = bad_needed_ff;
      fail_limit_in    = fail_limit_ff;
      sum_in           = sum_ff;
      count_in         = count_ff;
      oldest_in        = oldest_ff;
      bad_run_in       = bad_run_ff;
      last_grade_in    = last_grade_ff;
      grade_run_in     = grade_run_ff;
      fail_run_in      = fail_run_ff;
      reported_in      = reported_ff;
      connected_in     = connected_ff;
      mean_in          = mean_ff;
      ok_in            = ok_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         unique case (csr_index)
            lqm_pkg::CSR_GOOD_LIMIT:    good_limit_in    = csr_data;
            lqm_pkg::CSR_AVERAGE_LIMIT: avg_limit_in     = csr_data;
            lqm_pkg::CSR_STREAK_NEEDED: streak_needed_in = csr_data[lqm_pkg::RUN_W-1:0];
            lqm_pkg::CSR_BAD_NEEDED:    bad_needed_in    = csr_data[lqm_pkg::RUN_W-1:0];
            lqm_pkg::CSR_FAIL_LIMIT:    fail_limit_in    = csr_data[lqm_pkg::RUN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ok_in = req_data.probe_ok;
               if (req_data.probe_ok) begin
                  sum_in = sum_ff - lqm_pkg::SUM_W'(old_sample)
                         + lqm_pkg::SUM_W'(req_data.round_trip_ms);
                  if (full) begin
                     oldest_in = (oldest_ff == SLOT_W'(WINDOW - 1)) ? '0
                               : oldest_ff + 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (ok_ff) begin
                  fail_run_in  = '0;
                  connected_in = 1'b1;
                  mean_in      = mean_new;
                  if (grade == lqm_pkg::GRADE_BAD) begin
                     bad_run_in = (bad_run_ff == lqm_pkg::RUN_MAX) ? lqm_pkg::RUN_MAX
                                : bad_run_ff + 1'b1;
                  end else begin
                     bad_run_in = '0;
                  end
                  if (grade == last_grade_ff) begin
                     grade_run_in = (grade_run_ff == lqm_pkg::RUN_MAX) ? lqm_pkg::RUN_MAX
                                  : grade_run_ff + 1'b1;
                  end else begin
                     last_grade_in = grade;
                     grade_run_in  = lqm_pkg::RUN_W'(1);
                  end
                  if (bad_run_in >= bad_needed_ff) begin
                     reported_in = lqm_pkg::GRADE_BAD;
                  end else if (grade_run_in >= streak_needed_ff) begin
                     reported_in = grade;
                  end
               end else begin
                  fail_run_in = (fail_run_ff == lqm_pkg::RUN_MAX) ? lqm_pkg::RUN_MAX
                              : fail_run_ff + 1'b1;
                  if (fail_run_in >= fail_limit_ff) begin
                     connected_in = 1'b0;
                     reported_in  = lqm_pkg::GRADE_BAD;
                  end
               end
               rsp_in.link_grade = reported_in;
               rsp_in.link_up    = connected_in;
               rsp_in.mean_ms    = mean_in;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         good_limit_ff    <= lqm_pkg::MS_W'(60);
         avg_limit_ff     <= lqm_pkg::MS_W'(150);
         streak_needed_ff <= lqm_pkg::RUN_W'(3);
         bad_needed_ff    <= lqm_pkg::RUN_W'(3);
         fail_limit_ff    <= lqm_pkg::RUN_W'(3);
         sum_ff           <= '0;
         count_ff         <= '0;
         oldest_ff        <= '0;
         bad_run_ff       <= '0;
         last_grade_ff    <= lqm_pkg::GRADE_NONE;
         grade_run_ff     <= '0;
         fail_run_ff      <= '0;
         reported_ff      <= lqm_pkg::GRADE_GOOD;
         connected_ff     <= 1'b0;
         mean_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         good_limit_ff    <= good_limit_in;
         avg_limit_ff     <= avg_limit_in;
         streak_needed_ff <= streak_needed_in;
         bad_needed_ff    <= bad_needed_in;
         fail_limit_ff    <= fail_limit_in;
         sum_ff           <= sum_in;
         count_ff         <= count_in;
         oldest_ff        <= oldest_in;
         bad_run_ff       <= bad_run_in;
         last_grade_ff    <= last_grade_in;
         grade_run_ff     <= grade_run_in;
         fail_run_ff      <= fail_run_in;
         reported_ff      <= reported_in;
         connected_ff     <= connected_in;
         mean_ff          <= mean_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
   end

   // sample store, no reset; the oldest entry is read through a register ahead of use
   always_ff @(posedge clock) begin
      if (push) begin
         window_ff[wr_slot] <= req_data.round_trip_ms;
      end
      oldest_sample_ff <= window_ff[oldest_ff];
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LQM_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `LQM_ASSERT_NOW(a_done_only_dividing, clock, reset, div_done, state_ff == ST_DIVIDE)
   `LQM_ASSERT_NOW(a_grade_valid, clock, reset, rsp_valid,
                   rsp_data.link_grade != lqm_pkg::GRADE_NONE)

endmodule

`default_nettype wire

// ===== sv/lqm_serial_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module lqm_serial_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [lqm_pkg::SUM_W-1:0]  dividend,
   input  wire logic [lqm_pkg::CNT_W-1:0]  divisor,
   output logic                            done,
   output logic [lqm_pkg::SUM_W-1:0]       quotient
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [lqm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lqm_pkg::SUM_W-1:0]    quo_ff, quo_in;
   logic [lqm_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [lqm_pkg::CNT_W-1:0]    div_ff, div_in;

   logic [lqm_pkg::CNT_W:0]      trial;
   logic [lqm_pkg::CNT_W:0]      diff;
   logic                         fits;

   assign trial = {rem_ff, quo_ff[lqm_pkg::SUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[lqm_pkg::SUM_W-2:0], fits};
         rem_in  = fits ? diff[lqm_pkg::CNT_W-1:0] : trial[lqm_pkg::CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == lqm_pkg::STEP_W'(lqm_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
